>>> rtl/utf8_to_utf16_transcoder_core_assert.svh
// Assertion macros for the UTF-8 to UTF-16 transcoder
`ifndef UTF8_TO_UTF16_TRANSCODER_CORE_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_CORE_ASSERT_SVH

// implication in the same cycle
`define U2U_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u2u assertion failed");

// implication into the next cycle
`define U2U_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u2u assertion failed");

`endif

>>> rtl/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder
package u2u_pkg;

    localparam int COUNT_BITS = 24;
    localparam int CAP_W      = 24;
    localparam int TOTAL_W    = 24;
    localparam int CMP_W      = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;
    localparam int CP_W       = 21;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    localparam logic [7:0]      LEAD_MIN   = 8'hC2;
    localparam logic [7:0]      LEAD_MAX   = 8'hF4;
    localparam logic [5:0]      CONT_MASK  = 6'h3F;
    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0] BMP_MAX    = 21'h00FFFF;
    localparam logic [15:0]     HI_BASE    = 16'hD800 - 16'd64;
    localparam logic [15:0]     LO_BASE    = 16'hDC00;
    localparam logic [9:0]      LO_MASK    = 10'h3FF;
    localparam logic [CAP_W-1:0] CAP_RESET = {CAP_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_UNIT = 2'd0,
        KIND_OK   = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        kind_t              kind;
        logic [15:0]        code_unit;
        logic [TOTAL_W-1:0] total_units;
        logic               run_end;
    } out_item_t;

    // work for the back end produced by one input byte
    typedef struct packed {
        logic [1:0]         n_units;
        logic [15:0]        unit0;
        logic [15:0]        unit1;
        logic               has_end;
        logic               end_err;
        logic [TOTAL_W-1:0] total;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> rtl/u2u_front.sv
// Front end: accepts bytes, decodes UTF-8 and builds per-byte jobs
module u2u_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  u2u_pkg::in_item_t             in_data,
    input  logic [u2u_pkg::CAP_W-1:0]     capacity,
    input  u2u_pkg::q_status_t            q_st,
    output logic                          push,
    output u2u_pkg::job_t                 push_job
);

    logic [u2u_pkg::CP_W-1:0]       acc_reg, acc_next;
    logic [1:0]                     rem_reg, rem_next;
    logic                           err_reg, err_next;
    logic [u2u_pkg::COUNT_BITS-1:0] total_reg, total_next;

    logic [7:0]                     b;
    logic                           done;
    logic [u2u_pkg::CP_W-1:0]       cp;
    logic [1:0]                     n_cnt;
    logic [15:0]                    u0, u1;
    logic [u2u_pkg::COUNT_BITS-1:0] t1, t2, t_after;
    logic [u2u_pkg::CMP_W-1:0]      cap_x;
    logic                           emit0, emit1;
    logic                           accept;
    logic                           end_err;

    function automatic logic [u2u_pkg::COUNT_BITS-1:0] sat_inc(
        input logic [u2u_pkg::COUNT_BITS-1:0] v
    );
        logic [u2u_pkg::COUNT_BITS-1:0] r;
        r = (&v) ? v : v + 1'b1;
        return r;
    endfunction

    assign in_stall = q_st.full;
    assign accept   = in_valid && !in_stall;
    assign b        = in_data.in_byte;

    always_comb
    begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        err_next = err_reg;
        done     = 1'b0;
        cp       = '0;
        n_cnt    = 2'd0;
        u0       = '0;
        u1       = '0;
        if (!err_reg)
        begin
            if (rem_reg == 2'd0)
            begin
                if (!b[7])
                begin
                    cp   = {13'd0, b};
                    done = 1'b1;
                end
                else if (b < u2u_pkg::LEAD_MIN || b > u2u_pkg::LEAD_MAX)
                begin
                    err_next = 1'b1;
                end
                else if (b[7:5] == 3'b110)
                begin
                    acc_next = {16'd0, b[4:0]};
                    rem_next = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    acc_next = {17'd0, b[3:0]};
                    rem_next = 2'd2;
                end
                else
                begin
                    acc_next = {18'd0, b[2:0]};
                    rem_next = 2'd3;
                end
            end
            else
            begin
                if (b[7:6] != 2'b10)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    acc_next = {acc_reg[u2u_pkg::CP_W-7:0], b[5:0] & u2u_pkg::CONT_MASK};
                    rem_next = rem_reg - 2'd1;
                    if (rem_next == 2'd0)
                    begin
                        cp   = acc_next;
                        done = 1'b1;
                    end
                end
            end
            if (done)
            begin
                acc_next = '0;
                if (cp > u2u_pkg::CP_MAX)
                begin
                    err_next = 1'b1;
                end
                else if (cp > u2u_pkg::BMP_MAX)
                begin
                    n_cnt = 2'd2;
                    u0    = u2u_pkg::HI_BASE + {5'd0, cp[20:10]};
                    u1    = u2u_pkg::LO_BASE | {6'd0, cp[9:0] & u2u_pkg::LO_MASK};
                end
                else
                begin
                    n_cnt = 2'd1;
                    u0    = cp[15:0];
                end
            end
        end
    end

    assign t1    = sat_inc(total_reg);
    assign t2    = sat_inc(t1);
    assign cap_x = u2u_pkg::CMP_W'(capacity);
    assign emit0 = (n_cnt != 2'd0) && (u2u_pkg::CMP_W'(total_reg) < cap_x);
    assign emit1 = (n_cnt == 2'd2) && (u2u_pkg::CMP_W'(t1) < cap_x);

    always_comb
    begin
        case (n_cnt)
            2'd0:    t_after = total_reg;
            2'd1:    t_after = t1;
            default: t_after = t2;
        endcase
    end

    assign end_err = err_next || (rem_next != 2'd0);

    assign push = accept && (emit0 || in_data.end_of_string);

    always_comb
    begin
        push_job.n_units = {1'b0, emit0} + {1'b0, emit1};
        push_job.unit0   = u0;
        push_job.unit1   = u1;
        push_job.has_end = in_data.end_of_string;
        push_job.end_err = end_err;
        push_job.total   = end_err ? '0 : u2u_pkg::TOTAL_W'(t_after);
    end

    always_comb
    begin
        total_next = t_after;
        if (in_data.end_of_string)
        begin
            total_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            rem_reg   <= '0;
            err_reg   <= 1'b0;
            total_reg <= '0;
        end
        else if (accept)
        begin
            if (in_data.end_of_string)
            begin
                acc_reg <= '0;
                rem_reg <= '0;
                err_reg <= 1'b0;
            end
            else
            begin
                acc_reg <= acc_next;
                rem_reg <= rem_next;
                err_reg <= err_next;
            end
            total_reg <= total_next;
        end
    end

endmodule

>>> rtl/u2u_fifo.sv
// Short job queue between front and back end
module u2u_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  u2u_pkg::job_t      push_job,
    input  logic               pop,
    output u2u_pkg::job_t      head_job,
    output u2u_pkg::q_status_t q_st
);

    u2u_pkg::job_t              mem_reg [u2u_pkg::Q_DEPTH];
    logic [u2u_pkg::Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [u2u_pkg::Q_PTR_W:0]   count_reg, count_next;

    assign q_st.full  = (count_reg == (u2u_pkg::Q_PTR_W+1)'(u2u_pkg::Q_DEPTH));
    assign q_st.empty = (count_reg == '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/u2u_back.sv
// Back end: expands queued jobs into result items on the output register
module u2u_back (
    input  logic                clk,
    input  logic                rst_n,
    input  u2u_pkg::job_t       head_job,
    input  u2u_pkg::q_status_t  q_st,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output u2u_pkg::out_item_t  out_data
);

    logic [1:0]          idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    u2u_pkg::out_item_t  out_reg, out_next;
    logic [1:0]          n_res;
    logic                is_last;
    logic                load;

    assign n_res   = head_job.n_units + {1'b0, head_job.has_end};
    assign is_last = (idx_reg == n_res - 2'd1);
    assign load    = !q_st.empty && (!out_valid_reg || !out_stall);
    assign pop     = load && is_last;

    always_comb
    begin
        out_next = out_reg;
        idx_next = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
            if (idx_reg < head_job.n_units)
            begin
                out_next.kind        = u2u_pkg::KIND_UNIT;
                out_next.code_unit   = (idx_reg == 2'd0) ? head_job.unit0 : head_job.unit1;
                out_next.total_units = '0;
            end
            else
            begin
                out_next.kind        = head_job.end_err ? u2u_pkg::KIND_ERR : u2u_pkg::KIND_OK;
                out_next.code_unit   = '0;
                out_next.total_units = head_job.total;
            end
            out_next.run_end = is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> rtl/utf8_to_utf16_transcoder_core.sv
// Path: an accepted byte's job is written to the job queue, and its first result
// item is then loaded into the output register unless the output is stalled.
// Throughput: one byte per cycle while the output is not stalled and each byte
// gives at most one result; a byte giving two or three results holds the output
// register until all are out, and the four-job queue absorbs the difference.
// Reset: asynchronous, active low; clears decoder, queue, out_valid; cap_reg = FFFFFF.
`include "utf8_to_utf16_transcoder_core_assert.svh"

module utf8_to_utf16_transcoder_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  u2u_pkg::in_item_t         in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output u2u_pkg::out_item_t        out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [u2u_pkg::CAP_W-1:0] cfg_data
);

    logic [u2u_pkg::CAP_W-1:0] cap_reg;
    logic                      push, pop;
    u2u_pkg::job_t             push_job, head_job;
    u2u_pkg::q_status_t        q_st;
    logic                      res_done, res_err, res_zero;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= u2u_pkg::CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    u2u_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .capacity (cap_reg),
        .q_st     (q_st),
        .push     (push),
        .push_job (push_job)
    );

    u2u_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_st     (q_st)
    );

    u2u_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_st      (q_st),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign res_done = out_valid && (out_data.kind != u2u_pkg::KIND_UNIT);
    assign res_err  = out_valid && (out_data.kind == u2u_pkg::KIND_ERR);
    assign res_zero = (out_data.code_unit == 16'd0) && (out_data.total_units == '0);

    `U2U_ASSERT_IMP(a_end_is_last, clk, rst_n, res_done, out_data.run_end)
    `U2U_ASSERT_IMP(a_err_zero, clk, rst_n, res_err, res_zero)
    `U2U_ASSERT_NXT(a_queue_drains, clk, rst_n, !q_st.empty, out_valid)

endmodule

>>> verif/utf8_to_utf16_transcoder_core_test.sv
// Self-checking testbench for the UTF-8 to UTF-16 transcoder core
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_core_test;

    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 6;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_BYTES = 15;
    localparam int SCRIPT_LEN  = 24;

    localparam logic [20:0] UNICODE_MAX = 21'h10FFFF;
    localparam logic [20:0] PLANE0_MAX  = 21'h00FFFF;
    localparam logic [15:0] HIGH_BASE   = 16'hD800 - 16'd64;
    localparam logic [15:0] LOW_BASE    = 16'hDC00;

    localparam u2u_pkg::out_item_t NO_RESULT = '0;

    typedef struct {
        u2u_pkg::in_item_t  stim;
        bit                 typed;
        u2u_pkg::out_item_t want;
    } script_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    u2u_pkg::in_item_t             in_data;
    logic                          out_valid;
    logic                          out_stall;
    u2u_pkg::out_item_t            out_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [u2u_pkg::CAP_W-1:0]     cfg_data;

    // predictor state
    logic [20:0]                   point_acc;
    logic [1:0]                    cont_left;
    bit                            string_bad;
    logic [u2u_pkg::TOTAL_W-1:0]   unit_count;
    logic [u2u_pkg::CAP_W-1:0]     capacity;

    u2u_pkg::out_item_t            byte_results[$];
    u2u_pkg::out_item_t            units_due[$];

    int                            mismatches;
    int                            send_gap_max;
    int                            recv_gap_max;
    int                            recv_hold;
    int                            quiet_cycles;

    script_row_t script [SCRIPT_LEN] = '{
        '{'{8'h00, 1'b0}, 1'b1, '{u2u_pkg::KIND_UNIT, 16'h0000, 24'h0, 1'b1}},
        '{'{8'h7F, 1'b1}, 1'b0, NO_RESULT},
        '{'{8'hC2, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h80, 1'b0}, 1'b1, '{u2u_pkg::KIND_UNIT, 16'h0080, 24'h0, 1'b1}},
        '{'{8'hE0, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h80, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h80, 1'b0}, 1'b1, '{u2u_pkg::KIND_UNIT, 16'h0000, 24'h0, 1'b1}},
        '{'{8'hED, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'hA0, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h80, 1'b0}, 1'b1, '{u2u_pkg::KIND_UNIT, 16'hD800, 24'h0, 1'b1}},
        '{'{8'hF4, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h8F, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'hBF, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'hBF, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'hF4, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h90, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h80, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h80, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h41, 1'b1}, 1'b1, '{u2u_pkg::KIND_ERR, 16'h0000, 24'h0, 1'b1}},
        '{'{8'hC1, 1'b1}, 1'b1, '{u2u_pkg::KIND_ERR, 16'h0000, 24'h0, 1'b1}},
        '{'{8'hFF, 1'b1}, 1'b1, '{u2u_pkg::KIND_ERR, 16'h0000, 24'h0, 1'b1}},
        '{'{8'hC3, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h41, 1'b1}, 1'b1, '{u2u_pkg::KIND_ERR, 16'h0000, 24'h0, 1'b1}},
        '{'{8'hE2, 1'b1}, 1'b1, '{u2u_pkg::KIND_ERR, 16'h0000, 24'h0, 1'b1}}
    };

    utf8_to_utf16_transcoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function automatic void clear_string();
        point_acc  = '0;
        cont_left  = '0;
        string_bad = 1'b0;
        unit_count = '0;
    endfunction

    function automatic void add_result(input u2u_pkg::kind_t k, input logic [15:0] unit,
                                       input logic [u2u_pkg::TOTAL_W-1:0] total);
        u2u_pkg::out_item_t r;
        r.kind        = k;
        r.code_unit   = unit;
        r.total_units = total;
        r.run_end     = 1'b0;
        byte_results.push_back(r);
    endfunction

    // every unit is counted; only those below capacity go out
    function automatic void count_unit(input logic [15:0] unit);
        if (unit_count < capacity)
            add_result(u2u_pkg::KIND_UNIT, unit, '0);
        if (unit_count != '1)
            unit_count++;
    endfunction

    function automatic void transcode_byte(input u2u_pkg::in_item_t item);
        logic [7:0]  b;
        logic [20:0] cp;
        bit          done;
        b    = item.in_byte;
        cp   = '0;
        done = 1'b0;
        byte_results.delete();
        if (!string_bad)
        begin
            if (cont_left == 2'd0)
            begin
                if (b < 8'h80)
                begin
                    cp   = {13'd0, b};
                    done = 1'b1;
                end
                else if (b < 8'hC2 || b > 8'hF4)
                    string_bad = 1'b1;
                else if (b[7:5] == 3'b110)
                begin
                    point_acc = {16'd0, b[4:0]};
                    cont_left = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    point_acc = {17'd0, b[3:0]};
                    cont_left = 2'd2;
                end
                else
                begin
                    point_acc = {18'd0, b[2:0]};
                    cont_left = 2'd3;
                end
            end
            else if (b[7:6] != 2'b10)
                string_bad = 1'b1;
            else
            begin
                point_acc = {point_acc[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                begin
                    cp   = point_acc;
                    done = 1'b1;
                end
            end
            if (done)
            begin
                point_acc = '0;
                if (cp > UNICODE_MAX)
                    string_bad = 1'b1;
                else if (cp > PLANE0_MAX)
                begin
                    count_unit(HIGH_BASE + {5'd0, cp[20:10]});
                    count_unit(LOW_BASE | {6'd0, cp[9:0]});
                end
                else
                    count_unit(cp[15:0]);
            end
        end
        if (item.end_of_string)
        begin
            if (!string_bad && cont_left != 2'd0)
                string_bad = 1'b1;
            if (string_bad)
                add_result(u2u_pkg::KIND_ERR, '0, '0);
            else
                add_result(u2u_pkg::KIND_OK, '0, unit_count);
            clear_string();
        end
        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].run_end = 1'b1;
    endfunction

    task automatic send_item(input u2u_pkg::in_item_t item, input bit typed,
                             input u2u_pkg::out_item_t want);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        transcode_byte(item);
        if (typed)
        begin
            if (byte_results.size() != 1 || byte_results[0] != want)
                note_mismatch($sformatf("script row %h/%0d disagrees with prediction",
                                        item.in_byte, item.end_of_string));
            units_due.push_back(want);
        end
        else
            foreach (byte_results[i])
                units_due.push_back(byte_results[i]);
    endtask

    // random UTF-8 text, overlong forms and points above 10FFFF included, sometimes damaged
    task automatic send_random_string(output int sent);
        logic [7:0]        bytes_q[$];
        logic [20:0]       cp;
        u2u_pkg::in_item_t item;
        int                points;
        int                sel;
        int                pos;
        points = $urandom_range(1, 5);
        for (int p = 0; p < points; p++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 35)
                bytes_q.push_back({1'b0, 7'($urandom_range(0, 127))});
            else if (sel < 60)
            begin
                cp = 21'($urandom_range(21'h80, 21'h7FF));
                bytes_q.push_back({3'b110, cp[10:6]});
                bytes_q.push_back({2'b10, cp[5:0]});
            end
            else if (sel < 80)
            begin
                cp = 21'($urandom_range(0, 21'hFFFF));
                bytes_q.push_back({4'b1110, cp[15:12]});
                bytes_q.push_back({2'b10, cp[11:6]});
                bytes_q.push_back({2'b10, cp[5:0]});
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    cp = 21'($urandom_range(21'h110000, 21'h13FFFF));
                else
                    cp = 21'($urandom_range(0, 21'h10FFFF));
                bytes_q.push_back({5'b11110, cp[20:18]});
                bytes_q.push_back({2'b10, cp[17:12]});
                bytes_q.push_back({2'b10, cp[11:6]});
                bytes_q.push_back({2'b10, cp[5:0]});
            end
        end
        sel = $urandom_range(0, 99);
        pos = $urandom_range(0, bytes_q.size() - 1);
        if (sel < 12)
            bytes_q[pos] = 8'($urandom_range(0, 255));
        else if (sel < 20 && bytes_q.size() > 1)
            bytes_q = bytes_q[0:$urandom_range(0, bytes_q.size() - 2)];
        else if (sel < 26)
            bytes_q.insert(pos, 8'($urandom_range(0, 255)));
        foreach (bytes_q[i])
        begin
            item.in_byte       = bytes_q[i];
            item.end_of_string = (i == bytes_q.size() - 1);
            send_item(item, 1'b0, NO_RESULT);
        end
        sent = bytes_q.size();
    endtask

    task automatic wait_for_drain();
        while (units_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [u2u_pkg::CAP_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        capacity = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result side
    initial
    begin
        int                 gap;
        u2u_pkg::out_item_t got;
        u2u_pkg::out_item_t want;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (recv_hold > 0)
            begin
                gap       = recv_hold;
                recv_hold = 0;
            end
            else
                gap = $urandom_range(0, recv_gap_max);
            @(negedge clk);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got = out_data;
            if (units_due.size() == 0)
                note_mismatch($sformatf("unexpected item kind %0d unit %h total %0d",
                                        got.kind, got.code_unit, got.total_units));
            else
            begin
                want = units_due.pop_front();
                if (got.kind !== want.kind)
                    note_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
                if (got.code_unit !== want.code_unit)
                    note_mismatch($sformatf("code_unit %h, want %h",
                                            got.code_unit, want.code_unit));
                if (got.total_units !== want.total_units)
                    note_mismatch($sformatf("total_units %0d, want %0d",
                                            got.total_units, want.total_units));
                if (got.run_end !== want.run_end)
                    note_mismatch($sformatf("run_end %0b, want %0b",
                                            got.run_end, want.run_end));
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("utf8_to_utf16_transcoder_core regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        logic [u2u_pkg::CAP_W-1:0] caps [NUM_PHASES];
        int                        sent;
        int                        phase_bytes;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        mismatches   = 0;
        recv_hold    = 0;
        send_gap_max = 17;
        recv_gap_max = 17;
        capacity     = u2u_pkg::CAP_RESET;
        clear_string();
        caps = '{24'd0, 24'd1, 24'd3, 24'($urandom_range(2, 10)), 24'hFFFFFF,
                 24'($urandom_range(0, 24'hFFFFFF))};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            send_item(script[i].stim, script[i].typed, script[i].want);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            wait_for_drain();
            write_capacity(caps[p]);
            send_gap_max = (p % 3 == 1) ? 0 : 17;
            recv_gap_max = (p % 3 == 2) ? 0 : 17;
            if (p == 4)
            begin
                send_gap_max = 0;
                recv_gap_max = 0;
            end
            // fill the block while the result side holds off
            if (p == 2)
                recv_hold = 200;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                send_random_string(sent);
                phase_bytes += sent;
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;
        wait_for_drain();

        if (mismatches == 0)
            $display("utf8_to_utf16_transcoder_core regression: pass");
        else
            $display("utf8_to_utf16_transcoder_core regression: fail");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/u2u_pkg.sv
rtl/u2u_front.sv
rtl/u2u_fifo.sv
rtl/u2u_back.sv
rtl/utf8_to_utf16_transcoder_core.sv
verif/utf8_to_utf16_transcoder_core_test.sv
